// ===== sv/vvtp_pkg.sv =====
// vvtp_pkg: shared types, widths and register indexes for the vertex
// view transform and projection block; no dependencies
package vvtp_pkg;

    // fixed field widths
    localparam int CoordW   = 24;
    localparam int TrigW    = 16;
    localparam int TrigFrac = 14;
    localparam int ScreenW  = 16;
    localparam int FocalW   = 24;

    // internal datapath widths
    localparam int TransW   = 26;   // camera-relative coordinate
    localparam int Rot1W    = 28;   // after yaw
    localparam int Rot2W    = 30;   // after pitch
    localparam int Rot3W    = 32;   // after roll
    localparam int DenW     = 38;   // depth scaled by 256
    localparam int MagW     = 32;   // magnitude of a rolled coordinate
    localparam int ProdW    = FocalW + MagW;
    localparam int QuotW    = 17;   // quotient bits kept before saturation
    localparam int RemW     = 57;

    // register indexes
    localparam int RegIdxW = 3;
    localparam logic [RegIdxW-1:0] REG_CAM_X     = 3'd0;
    localparam logic [RegIdxW-1:0] REG_CAM_Y     = 3'd1;
    localparam logic [RegIdxW-1:0] REG_CAM_Z     = 3'd2;
    localparam logic [RegIdxW-1:0] REG_ROT_Y     = 3'd3;
    localparam logic [RegIdxW-1:0] REG_ROT_X     = 3'd4;
    localparam logic [RegIdxW-1:0] REG_ROT_Z     = 3'd5;
    localparam logic [RegIdxW-1:0] REG_FOCAL     = 3'd6;
    localparam logic [RegIdxW-1:0] REG_CENTER    = 3'd7;
    localparam int CfgDataW = 32;

    // register reset values
    localparam logic [31:0] ROT_RESET    = 32'h4000_0000;
    localparam logic [23:0] FOCAL_RESET  = 24'd89600;
    localparam logic [31:0] CENTER_RESET = 32'd22938000;

    localparam logic signed [ScreenW-1:0] SCR_MAX = 16'sh7FFF;
    localparam logic signed [ScreenW-1:0] SCR_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [CoordW-1:0] vert_x;
        logic signed [CoordW-1:0] vert_y;
        logic signed [CoordW-1:0] vert_z;
        logic                     end_of_list;
    } vvtp_in_t;

    typedef struct packed {
        logic signed [ScreenW-1:0] screen_x;
        logic signed [ScreenW-1:0] screen_y;
        logic                      behind_camera;
        logic                      last_out;
    } vvtp_out_t;

    typedef struct packed {
        logic signed [CoordW-1:0] cam_pos_x;
        logic signed [CoordW-1:0] cam_pos_y;
        logic signed [CoordW-1:0] cam_pos_z;
        logic [31:0]              rot_y_sincos;
        logic [31:0]              rot_x_sincos;
        logic [31:0]              rot_z_sincos;
        logic [FocalW-1:0]        focal_length;
        logic [31:0]              screen_center;
    } vvtp_cfg_t;

    // request passed from the front to the back
    typedef struct packed {
        logic [MagW-1:0] x_mag;
        logic            x_neg;
        logic [MagW-1:0] y_mag;
        logic            y_neg;
        logic [DenW-1:0] den;
        logic            behind;
        logic            last;
    } vvtp_item_t;

endpackage

// ===== sv/vvtp_front.sv =====
// vvtp_front: translation and the three rotations, pipelined one
// multiply level per stage; depends on vvtp_pkg
module vvtp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  vvtp_pkg::vvtp_in_t  vert,
    input  vvtp_pkg::vvtp_cfg_t cfg,
    output logic                item_valid,
    output vvtp_pkg::vvtp_item_t item
);
    import vvtp_pkg::*;

    logic signed [TrigW-1:0] cy, sy, cx, sx, cz, sz;

    logic [6:0] vld_reg, vld_next;

    // stage 0: camera relative
    logic signed [TransW-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [TransW-1:0] tx_next, ty_next, tz_next;
    // stage 1: yaw products
    logic signed [41:0] ya_reg, yb_reg, yc_reg, yd_reg;
    logic signed [TransW-1:0] y1a_reg;
    // stage 2: yaw result
    logic signed [Rot1W-1:0] x1_reg, z1_reg;
    logic signed [TransW-1:0] y1b_reg;
    logic signed [42:0] x1_sum, z1_sum;
    // stage 3: pitch products
    logic signed [43:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [Rot1W-1:0] x1c_reg;
    logic signed [Rot1W-1:0] y1_ext;
    // stage 4: pitch result
    logic signed [Rot2W-1:0] y2_reg, z2_reg;
    logic signed [Rot1W-1:0] x1d_reg;
    logic signed [44:0] y2_sum, z2_sum;
    // stage 5: roll products
    logic signed [45:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic signed [Rot2W-1:0] x1_ext;
    logic behind_reg;
    logic [DenW-1:0] den_reg;
    // stage 6: roll result
    logic signed [46:0] y3_sum, x3_sum;
    logic signed [Rot3W-1:0] x3, y3;
    vvtp_item_t item_reg, item_next;

    logic [5:0] last_reg;

    assign cy = cfg.rot_y_sincos[31:16];
    assign sy = cfg.rot_y_sincos[15:0];
    assign cx = cfg.rot_x_sincos[31:16];
    assign sx = cfg.rot_x_sincos[15:0];
    assign cz = cfg.rot_z_sincos[31:16];
    assign sz = cfg.rot_z_sincos[15:0];

    // translation, y negated before the camera subtract
    always_comb
    begin
        tx_next = {{2{vert.vert_x[CoordW-1]}}, vert.vert_x}
                - {{2{cfg.cam_pos_x[CoordW-1]}}, cfg.cam_pos_x};
        ty_next = -{{2{vert.vert_y[CoordW-1]}}, vert.vert_y}
                - {{2{cfg.cam_pos_y[CoordW-1]}}, cfg.cam_pos_y};
        tz_next = {{2{vert.vert_z[CoordW-1]}}, vert.vert_z}
                - {{2{cfg.cam_pos_z[CoordW-1]}}, cfg.cam_pos_z};
    end

    // rotation sums with arithmetic shift by the trig fraction
    always_comb
    begin
        x1_sum = {ya_reg[41], ya_reg} + {yb_reg[41], yb_reg};
        z1_sum = {yd_reg[41], yd_reg} - {yc_reg[41], yc_reg};
        y1_ext = {{2{y1b_reg[TransW-1]}}, y1b_reg};
        y2_sum = {pa_reg[43], pa_reg} + {pb_reg[43], pb_reg};
        z2_sum = {pd_reg[43], pd_reg} - {pc_reg[43], pc_reg};
        x1_ext = {{2{x1d_reg[Rot1W-1]}}, x1d_reg};
        y3_sum = {ra_reg[45], ra_reg} + {rb_reg[45], rb_reg};
        x3_sum = {rd_reg[45], rd_reg} - {rc_reg[45], rc_reg};
        x3     = x3_sum[TrigFrac+Rot3W-1:TrigFrac];
        y3     = y3_sum[TrigFrac+Rot3W-1:TrigFrac];
    end

    // request toward the queue
    always_comb
    begin
        item_next.x_neg  = x3[Rot3W-1];
        item_next.x_mag  = x3[Rot3W-1] ? MagW'(-x3) : MagW'(x3);
        item_next.y_neg  = y3[Rot3W-1];
        item_next.y_mag  = y3[Rot3W-1] ? MagW'(-y3) : MagW'(y3);
        item_next.den    = den_reg;
        item_next.behind = behind_reg;
        item_next.last   = last_reg[5];
    end

    assign vld_next = {vld_reg[5:0], accept};

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[4:0], vert.end_of_list};
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        tz_reg   <= tz_next;

        ya_reg  <= cy * tx_reg;
        yb_reg  <= sy * tz_reg;
        yc_reg  <= sy * tx_reg;
        yd_reg  <= cy * tz_reg;
        y1a_reg <= ty_reg;

        x1_reg  <= x1_sum[TrigFrac+Rot1W-1:TrigFrac];
        z1_reg  <= z1_sum[TrigFrac+Rot1W-1:TrigFrac];
        y1b_reg <= y1a_reg;

        pa_reg  <= cx * y1_ext;
        pb_reg  <= sx * z1_reg;
        pc_reg  <= sx * y1_ext;
        pd_reg  <= cx * z1_reg;
        x1c_reg <= x1_reg;

        y2_reg  <= y2_sum[TrigFrac+Rot2W-1:TrigFrac];
        z2_reg  <= z2_sum[TrigFrac+Rot2W-1:TrigFrac];
        x1d_reg <= x1c_reg;

        ra_reg     <= cz * y2_reg;
        rb_reg     <= sz * x1_ext;
        rc_reg     <= sz * y2_reg;
        rd_reg     <= cz * x1_ext;
        behind_reg <= z2_reg[Rot2W-1] || (z2_reg == '0);
        den_reg    <= {z2_reg, 8'd0};

        item_reg <= item_next;
    end

    assign item_valid = vld_reg[6];
    assign item       = item_reg;

endmodule

// ===== sv/vvtp_queue.sv =====
// vvtp_queue: two-entry queue between front and back; the back side
// drains one request per cycle; depends on vvtp_pkg
module vvtp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  vvtp_pkg::vvtp_item_t wr_data,
    output logic                 rd_valid,
    output vvtp_pkg::vvtp_item_t rd_data
);
    import vvtp_pkg::*;

    vvtp_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop      = (count_reg != 2'd0);
    assign rd_valid = pop;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/vvtp_back.sv =====
// vvtp_back: focal multiply, pipelined restoring divide by the scaled
// depth, centering and saturation; depends on vvtp_pkg
module vvtp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  vvtp_pkg::vvtp_item_t in_item,
    input  vvtp_pkg::vvtp_cfg_t  cfg,
    output logic                 done,
    output vvtp_pkg::vvtp_out_t  result
);
    import vvtp_pkg::*;

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [QuotW-1:0] q;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t           lx;
        lane_t           ly;
        logic [DenW-1:0] den;
        logic            x_neg;
        logic            y_neg;
        logic            behind;
        logic            last;
    } div_t;

    // focal multiply stage
    logic            mv_reg;
    logic [ProdW-1:0] mx_reg, my_reg;
    logic [DenW-1:0] mden_reg;
    logic            mxn_reg, myn_reg, mbeh_reg, mlast_reg;

    logic   dv_reg [QuotW+1];
    div_t   dd_reg [QuotW+1];
    div_t   dd_next [QuotW+1];
    logic [RemW-1:0] top_div;

    logic      done_reg;
    vvtp_out_t result_reg, result_next;

    function automatic lane_t div_step(lane_t l, logic [RemW-1:0] sub, int bit_pos);
        lane_t r;
        r = l;
        if (!l.ovf && (l.rem >= sub))
        begin
            r.rem        = l.rem - sub;
            r.q[bit_pos] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [ScreenW-1:0] finish(
        logic [15:0] center, lane_t l, logic neg, logic behind);
        logic [QuotW-1:0]  qv;
        logic              nz;
        logic signed [18:0] c19, q19, v1, v;
        logic signed [ScreenW-1:0] r;
        qv  = l.ovf ? '1 : l.q;
        nz  = (l.rem != '0);
        c19 = {3'b000, center};
        q19 = {2'b00, qv};
        v1  = c19 - q19 - {18'd0, nz};
        if (!neg)
        begin
            v = c19 + q19;
        end
        else if (v1[18])
        begin
            v = c19 - q19;
        end
        else
        begin
            v = v1;
        end
        priority if (behind)
        begin
            r = neg ? SCR_MIN : SCR_MAX;
        end
        else if (v > 19'sd32767)
        begin
            r = SCR_MAX;
        end
        else if (v < -19'sd32768)
        begin
            r = SCR_MIN;
        end
        else
        begin
            r = v[ScreenW-1:0];
        end
        return r;
    endfunction

    // overflow check and divider steps, one quotient bit per stage
    assign top_div = RemW'({mden_reg, {QuotW{1'b0}}});

    always_comb
    begin
        dd_next[0].lx.rem = RemW'(mx_reg);
        dd_next[0].lx.q   = '0;
        dd_next[0].lx.ovf = (RemW'(mx_reg) >= top_div);
        dd_next[0].ly.rem = RemW'(my_reg);
        dd_next[0].ly.q   = '0;
        dd_next[0].ly.ovf = (RemW'(my_reg) >= top_div);
        dd_next[0].den    = mden_reg;
        dd_next[0].x_neg  = mxn_reg;
        dd_next[0].y_neg  = myn_reg;
        dd_next[0].behind = mbeh_reg;
        dd_next[0].last   = mlast_reg;
        for (int k = 1; k <= QuotW; k++)
        begin
            dd_next[k]    = dd_reg[k-1];
            dd_next[k].lx = div_step(dd_reg[k-1].lx,
                                     RemW'(dd_reg[k-1].den) << (QuotW - k), QuotW - k);
            dd_next[k].ly = div_step(dd_reg[k-1].ly,
                                     RemW'(dd_reg[k-1].den) << (QuotW - k), QuotW - k);
        end
    end

    // final centering and saturation
    always_comb
    begin
        result_next.screen_x      = finish(cfg.screen_center[31:16], dd_reg[QuotW].lx,
                                           dd_reg[QuotW].x_neg, dd_reg[QuotW].behind);
        result_next.screen_y      = finish(cfg.screen_center[15:0], dd_reg[QuotW].ly,
                                           dd_reg[QuotW].y_neg, dd_reg[QuotW].behind);
        result_next.behind_camera = dd_reg[QuotW].behind;
        result_next.last_out      = dd_reg[QuotW].last;
    end

    // valid chain and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k <= QuotW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            mv_reg    <= in_valid;
            dv_reg[0] <= mv_reg;
            for (int k = 1; k <= QuotW; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            done_reg <= dv_reg[QuotW];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mx_reg    <= cfg.focal_length * in_item.x_mag;
        my_reg    <= cfg.focal_length * in_item.y_mag;
        mden_reg  <= in_item.den;
        mxn_reg   <= in_item.x_neg;
        myn_reg   <= in_item.y_neg;
        mbeh_reg  <= in_item.behind;
        mlast_reg <= in_item.last;
        for (int k = 0; k <= QuotW; k++)
        begin
            dd_reg[k] <= dd_next[k];
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/vertex_view_transform_project_core.sv =====
// vertex view transform and perspective projection, top level
// throughput: one vertex per cycle; multipliers and the 17-step divider are
// fully pipelined and the back drains the queue every cycle, so busy stays low
// reset: clears all valid bits and returns the configuration registers to their defaults
// depends on vvtp_pkg, vvtp_front, vvtp_queue, vvtp_back
module vertex_view_transform_project_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  vvtp_pkg::vvtp_in_t                     vert,
    output logic                                   done,
    output vvtp_pkg::vvtp_out_t                    result,
    input  logic                                   cfg_we,
    input  logic [vvtp_pkg::RegIdxW-1:0]           cfg_idx,
    input  logic [vvtp_pkg::CfgDataW-1:0]          cfg_wdata
);
    import vvtp_pkg::*;

    vvtp_cfg_t  cfg_reg;
    logic       accept;
    logic       item_valid;
    vvtp_item_t item;
    logic       q_valid;
    vvtp_item_t q_item;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_pos_x     <= '0;
            cfg_reg.cam_pos_y     <= '0;
            cfg_reg.cam_pos_z     <= '0;
            cfg_reg.rot_y_sincos  <= ROT_RESET;
            cfg_reg.rot_x_sincos  <= ROT_RESET;
            cfg_reg.rot_z_sincos  <= ROT_RESET;
            cfg_reg.focal_length  <= FOCAL_RESET;
            cfg_reg.screen_center <= CENTER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CAM_X:  cfg_reg.cam_pos_x     <= cfg_wdata[CoordW-1:0];
                REG_CAM_Y:  cfg_reg.cam_pos_y     <= cfg_wdata[CoordW-1:0];
                REG_CAM_Z:  cfg_reg.cam_pos_z     <= cfg_wdata[CoordW-1:0];
                REG_ROT_Y:  cfg_reg.rot_y_sincos  <= cfg_wdata;
                REG_ROT_X:  cfg_reg.rot_x_sincos  <= cfg_wdata;
                REG_ROT_Z:  cfg_reg.rot_z_sincos  <= cfg_wdata;
                REG_FOCAL:  cfg_reg.focal_length  <= cfg_wdata[FocalW-1:0];
                REG_CENTER: cfg_reg.screen_center <= cfg_wdata;
                default:    cfg_reg.screen_center <= cfg_reg.screen_center;
            endcase
        end
    end

    // front: translate and rotate
    vvtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .vert       (vert),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item)
    );

    // queue between front and back
    vvtp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (item_valid),
        .wr_data  (item),
        .rd_valid (q_valid),
        .rd_data  (q_item)
    );

    // back: project and saturate
    vvtp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_item),
        .cfg      (cfg_reg),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== sv/vvtp_checker.sv =====
// vvtp_checker: port-level checks for the projection core and its bind
// depends on vvtp_pkg
module vvtp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input vvtp_pkg::vvtp_out_t result
);
    import vvtp_pkg::*;

    // every accepted request yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##28 done)
        else $error("result strobe missing after accepted request");

    // no result without a matching request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 28))
        else $error("result strobe without a request");

    // a point behind the camera reports saturated coordinates
    a_behind_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.behind_camera) |->
            ((result.screen_x == SCR_MAX) || (result.screen_x == SCR_MIN)) &&
            ((result.screen_y == SCR_MAX) || (result.screen_y == SCR_MIN)))
        else $error("behind camera result not saturated");

endmodule

bind vertex_view_transform_project_core vvtp_checker u_vvtp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/tb_vertex_view_transform_project_core.sv =====
// testbench for vertex_view_transform_project_core: directed and random vertices
// checked against a behavioral projection model; depends on vvtp_pkg and the core
`timescale 1ns / 1ps

module tb_vertex_view_transform_project_core;
    import vvtp_pkg::*;

    localparam int Latency   = 27;
    localparam int NumRandom = 1250;
    localparam int WatchMax  = 20000;

    // expected screen points, oldest first
    class screen_board;
        vvtp_out_t pending[$];
        int        errors;
        longint    checked;

        function void note_vertex(vvtp_out_t p);
            pending.push_back(p);
        endfunction

        function void check_point(vvtp_out_t got);
            vvtp_out_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.screen_x !== want.screen_x)
            begin
                $error("screen_x exp %0d got %0d", want.screen_x, got.screen_x);
                errors++;
            end
            if (got.screen_y !== want.screen_y)
            begin
                $error("screen_y exp %0d got %0d", want.screen_y, got.screen_y);
                errors++;
            end
            if (got.behind_camera !== want.behind_camera)
            begin
                $error("behind_camera exp %0b got %0b", want.behind_camera,
                       got.behind_camera);
                errors++;
            end
            if (got.last_out !== want.last_out)
            begin
                $error("last_out exp %0b got %0b", want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    vvtp_in_t    vert;
    logic        done;
    vvtp_out_t   result;
    logic        cfg_we;
    logic [RegIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_wdata;

    vertex_view_transform_project_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vert      (vert),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    screen_board board;
    vvtp_cfg_t   view;
    int          idle_cycles;
    int          n_behind;
    int          n_sat;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // camera position, rotations, focal and center as the block holds them
    function automatic vvtp_out_t project_vertex(vvtp_in_t v);
        longint tx, ty, tz, cy, sy, cx, sx, cz, sz;
        longint x1, y1, z1, y2, z2, x3, y3, f, hw, hh, den, q;
        vvtp_out_t p;
        tx = longint'(v.vert_x) - longint'(view.cam_pos_x);
        ty = -longint'(v.vert_y) - longint'(view.cam_pos_y);
        tz = longint'(v.vert_z) - longint'(view.cam_pos_z);
        cy = longint'($signed(view.rot_y_sincos[31:16]));
        sy = longint'($signed(view.rot_y_sincos[15:0]));
        cx = longint'($signed(view.rot_x_sincos[31:16]));
        sx = longint'($signed(view.rot_x_sincos[15:0]));
        cz = longint'($signed(view.rot_z_sincos[31:16]));
        sz = longint'($signed(view.rot_z_sincos[15:0]));
        // arithmetic shifts floor toward minus infinity
        x1 = (cy * tx + sy * tz) >>> TrigFrac;
        z1 = (-sy * tx + cy * tz) >>> TrigFrac;
        y1 = ty;
        y2 = (cx * y1 + sx * z1) >>> TrigFrac;
        z2 = (-sx * y1 + cx * z1) >>> TrigFrac;
        y3 = (cz * y2 + sz * x1) >>> TrigFrac;
        x3 = (-sz * y2 + cz * x1) >>> TrigFrac;
        f  = longint'(view.focal_length);
        hw = longint'(view.screen_center[31:16]);
        hh = longint'(view.screen_center[15:0]);
        p.last_out = v.end_of_list;
        p.behind_camera = (z2 <= 0);
        if (z2 <= 0)
        begin
            p.screen_x = (x3 >= 0) ? SCR_MAX : SCR_MIN;
            p.screen_y = (y3 >= 0) ? SCR_MAX : SCR_MIN;
        end
        else
        begin
            den = z2 * 256;
            q = (hw * den + f * x3) / den;
            p.screen_x = (q > 32767) ? SCR_MAX : (q < -32768) ? SCR_MIN : q[15:0];
            q = (hh * den + f * y3) / den;
            p.screen_y = (q > 32767) ? SCR_MAX : (q < -32768) ? SCR_MIN : q[15:0];
        end
        return p;
    endfunction

    // result side: every strobe is one screen point
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_point(result);
            if (result.screen_x == SCR_MAX || result.screen_x == SCR_MIN)
                n_sat++;
            if (result.behind_camera)
                n_behind++;
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchMax)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CAM_X:  view.cam_pos_x     = val[23:0];
            REG_CAM_Y:  view.cam_pos_y     = val[23:0];
            REG_CAM_Z:  view.cam_pos_z     = val[23:0];
            REG_ROT_Y:  view.rot_y_sincos  = val;
            REG_ROT_X:  view.rot_x_sincos  = val;
            REG_ROT_Z:  view.rot_z_sincos  = val;
            REG_FOCAL:  view.focal_length  = val[23:0];
            REG_CENTER: view.screen_center = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all results, then past the pipeline depth
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    // start stays high across back-to-back requests
    task automatic send_vertex(vvtp_in_t v);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                          : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        vert  <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_vertex(project_vertex(v));
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_trig();
        logic [15:0] t;
        case ($urandom_range(0, 5))
            0: t = 16'sh4000;
            1: t = 16'shC000;
            2: t = 16'h0000;
            3: t = 16'h7FFF;
            4: t = 16'h8000;
            default: t = 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
        return t;
    endfunction

    // vertex at moderate scale, mostly at positive depth, or fully random
    function automatic vvtp_in_t rand_vertex();
        vvtp_in_t v;
        v.end_of_list = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0)
        begin
            v.vert_x = 24'($urandom);
            v.vert_y = 24'($urandom);
            v.vert_z = 24'($urandom);
        end
        else
        begin
            v.vert_x = 24'($signed($urandom_range(0, 40000)) - 20000);
            v.vert_y = 24'($signed($urandom_range(0, 40000)) - 20000);
            v.vert_z = 24'($signed($urandom_range(0, 60000)) - 5000);
        end
        return v;
    endfunction

    task automatic random_view(bit extremes);
        write_reg(REG_CAM_X, extremes ? 32'h800000 : 32'($signed($urandom_range(0, 4000)) - 2000));
        write_reg(REG_CAM_Y, extremes ? 32'h7FFFFF : 32'($signed($urandom_range(0, 4000)) - 2000));
        write_reg(REG_CAM_Z, extremes ? 32'hFFFFFF : 32'($signed($urandom_range(0, 4000)) - 4000));
        write_reg(REG_ROT_Y, {rand_trig(), rand_trig()});
        write_reg(REG_ROT_X, {rand_trig(), rand_trig()});
        write_reg(REG_ROT_Z, {rand_trig(), rand_trig()});
        write_reg(REG_FOCAL, extremes ? 32'hFFFFFF : $urandom_range(0, 200000));
        write_reg(REG_CENTER, extremes ? 32'hFFFF_FFFF : $urandom);
    endtask

    initial
    begin
        vvtp_in_t v;
        int k;
        board = new();
        idle_cycles = 0;
        n_behind = 0;
        n_sat = 0;
        rst_n = 1'b0;
        start = 1'b0;
        vert = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_CAM_X;
        cfg_wdata = '0;
        view.cam_pos_x = '0;
        view.cam_pos_y = '0;
        view.cam_pos_z = '0;
        view.rot_y_sincos = ROT_RESET;
        view.rot_x_sincos = ROT_RESET;
        view.rot_z_sincos = ROT_RESET;
        view.focal_length = FOCAL_RESET;
        view.screen_center = CENTER_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset view, field extremes, depth zero and behind, saturation
        v = '{24'sd0, 24'sd0, 24'sd2560, 1'b0};        send_vertex(v);
        v = '{24'sd256, -24'sd256, 24'sd256, 1'b1};    send_vertex(v);
        v = '{24'sd100, 24'sd100, 24'sd0, 1'b0};       send_vertex(v);
        v = '{-24'sd100, 24'sd100, -24'sd512, 1'b0};   send_vertex(v);
        v = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sd1, 1'b0}; send_vertex(v);
        v = '{24'sh800000, 24'sh800000, 24'sd1, 1'b1}; send_vertex(v);
        v = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0}; send_vertex(v);
        v = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1}; send_vertex(v);
        v = '{24'sh7FFFFF, 24'sd0, 24'sd256, 1'b0};    send_vertex(v);
        v = '{-24'sd1, -24'sd1, 24'sh7FFFFF, 1'b0};    send_vertex(v);
        stop_sending();
        drain();

        // extreme view registers, then a negated yaw, other fixed trig values, zero focal and center
        random_view(1'b1);
        for (k = 0; k < 6; k++)
            send_vertex(rand_vertex());
        stop_sending();
        drain();
        write_reg(REG_CAM_X, 32'hFF00_0000);
        write_reg(REG_ROT_Y, {16'shC000, 16'h0000});
        write_reg(REG_ROT_X, {16'h0000, 16'sh4000});
        write_reg(REG_ROT_Z, {16'h8000, 16'h7FFF});
        write_reg(REG_FOCAL, 32'h0);
        write_reg(REG_CENTER, 32'h0);
        for (k = 0; k < 6; k++)
            send_vertex(rand_vertex());
        stop_sending();
        drain();

        // random phases with a fresh view each time
        for (k = 0; k < NumRandom; k++)
        begin
            if (k % 125 == 0)
            begin
                stop_sending();
                drain();
                random_view(1'b0);
            end
            send_vertex(rand_vertex());
        end
        stop_sending();
        drain();

        $display("checked %0d screen points, %0d behind the camera, %0d saturated in x",
                 board.checked, n_behind, n_sat);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== vertex_view_transform_project_core.f =====
sv/vvtp_pkg.sv
sv/vvtp_front.sv
sv/vvtp_queue.sv
sv/vvtp_back.sv
sv/vertex_view_transform_project_core.sv
sv/vvtp_checker.sv
tb/tb_vertex_view_transform_project_core.sv
